// ===== hw/rtl/cnwf_pkg.sv =====
package cnwf_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned YearOutW = 12;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned WdayW    = 3;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  // Default last year of the counting range.
  localparam int unsigned MaxYearDefault = 4095;

  // Reset date: Tuesday 1850-01-01.
  localparam int unsigned StartYear = 1850;
  localparam logic [6:0]  StartMod100 = 7'd50;
  localparam logic [8:0]  StartMod400 = 9'd250;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [DayW-1:0]   DayLastDec = 5'd31;
  localparam logic [WdayW-1:0]  WdayMonday = 3'd1;
  localparam logic [WdayW-1:0]  WdayTuesday = 3'd2;
  localparam logic [WdayW-1:0]  WdaySunday = 3'd7;
  localparam logic [CountW-1:0] CountMax = 3'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxMonth   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxCount   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxWeekday = 2'd2;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [CountW-1:0] count;
    logic [WdayW-1:0]  weekday;
  } cnwf_cfg_t;

  typedef struct packed {
    logic [YearOutW-1:0] year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [WdayW-1:0]    weekday;
    logic                is_target;
    logic                none_year;
  } cnwf_result_t;

  // Number of days in a month, given whether the year is a leap year.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (m != MonthFeb) begin
      len = 5'd31;
    end else if (leap) begin
      len = 5'd29;
    end else begin
      len = 5'd28;
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/cnwf_cfg.sv =====
module cnwf_cfg import cnwf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cnwf_cfg_t           cfg_o
);

  cnwf_cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CfgIdxMonth:   cfg_d.month   = wr_data_i;
        CfgIdxCount:   cfg_d.count   = wr_data_i[CountW-1:0];
        CfgIdxWeekday: cfg_d.weekday = wr_data_i[WdayW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.month   <= MonthJan;
      cfg_q.count   <= 3'd1;
      cfg_q.weekday <= WdayMonday;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/cnwf_core.sv =====
module cnwf_core import cnwf_pkg::*; #(
  parameter int unsigned MaxYear = MaxYearDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         advance_i,
  input  cnwf_cfg_t    cfg_i,
  output cnwf_result_t res_o
);

  localparam int unsigned YearW = $clog2(MaxYear + 1);

  logic [YearW-1:0]  year_q, year_d;
  logic [6:0]        mod100_q, mod100_d;
  logic [8:0]        mod400_q, mod400_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [WdayW-1:0]  wday_q, wday_d;
  logic [CountW-1:0] count_q, count_d;
  logic              found_q, found_d;

  logic              leap;
  logic [DayW-1:0]   mlen;
  logic              match;
  logic [CountW-1:0] count_inc;
  logic              hit;
  logic              found_next;
  logic              last_day;
  logic              at_end;

  // Leap year from the running year residues.
  assign leap = ((year_q[1:0] == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
  assign mlen = month_len(month_q, leap);

  // Occurrence counting for the wanted weekday in the wanted month.
  assign match      = (month_q == cfg_i.month) && (wday_q == cfg_i.weekday);
  assign count_inc  = (match && (count_q != CountMax)) ? count_q + 3'd1 : count_q;
  assign hit        = match && (count_inc == cfg_i.count) && !found_q;
  assign found_next = found_q | hit;
  assign last_day   = (month_q == MonthDec) && (day_q == DayLastDec);
  assign at_end     = last_day && (year_q >= YearW'(MaxYear));

  // Result of the current day.
  always_comb begin
    res_o.year      = year_q[YearOutW-1:0];
    res_o.month     = month_q;
    res_o.day       = day_q;
    res_o.weekday   = wday_q;
    res_o.is_target = hit;
    res_o.none_year = last_day && !found_next;
  end

  // Next date and counters.
  always_comb begin
    year_d   = year_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    month_d  = month_q;
    day_d    = day_q;
    wday_d   = wday_q;
    count_d  = count_q;
    found_d  = found_q;
    if (step_i && advance_i && !at_end) begin
      count_d = count_inc;
      found_d = found_next;
      wday_d  = (wday_q == WdaySunday) ? WdayMonday : wday_q + 3'd1;
      if (day_q == mlen) begin
        day_d = DayFirst;
        if (month_q == MonthDec) begin
          month_d  = MonthJan;
          year_d   = year_q + YearW'(1);
          mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
          count_d  = '0;
          found_d  = 1'b0;
        end else begin
          month_d = month_q + 4'd1;
        end
      end else begin
        day_d = day_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= YearW'(StartYear);
      mod100_q <= StartMod100;
      mod400_q <= StartMod400;
      month_q  <= MonthJan;
      day_q    <= DayFirst;
      wday_q   <= WdayTuesday;
      count_q  <= '0;
      found_q  <= 1'b0;
    end else begin
      year_q   <= year_d;
      mod100_q <= mod100_d;
      mod400_q <= mod400_d;
      month_q  <= month_d;
      day_q    <= day_d;
      wday_q   <= wday_d;
      count_q  <= count_d;
      found_q  <= found_d;
    end
  end

  // The date always stays a real calendar date.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= MonthJan) && (month_q <= MonthDec))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_q >= DayFirst) && (day_q <= mlen))
    else $error("day beyond month length");

  // A day advance always moves the weekday on.
  a_wday_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && advance_i && !at_end) |=> (wday_q != $past(wday_q)))
    else $error("weekday did not advance");

endmodule

// ===== hw/rtl/cnwf_out_buf.sv =====
module cnwf_out_buf import cnwf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cnwf_result_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         stall_i,
  output cnwf_result_t data_o
);

  logic         out_valid_q;
  logic         skid_valid_q;
  cnwf_result_t out_q;
  cnwf_result_t skid_q;
  logic         pop;

  assign pop = out_valid_q && !stall_i;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && stall_i) |=> skid_valid_q)
    else $error("item lost while output stalled");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !skid_valid_q && !push_i) |=> !out_valid_q)
    else $error("item repeated after being taken");

endmodule

// ===== hw/rtl/calendar_nth_weekday_finder_top.sv =====
// Gregorian day counter that starts at Tuesday 1850-01-01 and reports, for every input item,
// the current date, its weekday, whether it is the configured nth weekday of the configured
// month, and on 31 December whether no such day occurred that year; advance_i = 1 then moves
// the date on by one day, and the counter holds at 31 December of MaxYear. The block takes one
// item per clock cycle unless in_stall_o is high: the whole update is one pass of logic from the
// date registers into the output register, or into the skid entry while the output is stalled.
// A two-entry output buffer lets an item be accepted while an earlier result is still stalled;
// in_stall_o rises only when both entries are full. Configuration writes are always ready and
// take effect from the next item; they belong to idle periods.
module calendar_nth_weekday_finder_top import cnwf_pkg::*; #(
  parameter int unsigned MaxYear = MaxYearDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input item channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                advance_i,
  // Result item channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [YearOutW-1:0] cur_year_o,
  output logic [MonthW-1:0]   cur_month_o,
  output logic [DayW-1:0]     cur_day_o,
  output logic [WdayW-1:0]    cur_weekday_o,
  output logic                is_target_day_o,
  output logic                none_this_year_o
);

  cnwf_cfg_t    cfg;
  cnwf_result_t core_res;
  cnwf_result_t out_res;
  logic         buf_full;
  logic         in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_accept   = in_valid_i && !buf_full;

  // Target registers.
  cnwf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Date state and day evaluation.
  cnwf_core #(
    .MaxYear (MaxYear)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_accept),
    .advance_i (advance_i),
    .cfg_i     (cfg),
    .res_o     (core_res)
  );

  // Result register and skid entry.
  cnwf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (core_res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign cur_year_o       = out_res.year;
  assign cur_month_o      = out_res.month;
  assign cur_day_o        = out_res.day;
  assign cur_weekday_o    = out_res.weekday;
  assign is_target_day_o  = out_res.is_target;
  assign none_this_year_o = out_res.none_year;

endmodule

// ===== tb/calendar_nth_weekday_finder_top_tb.sv =====
module calendar_nth_weekday_finder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cnwf_pkg::*;

  // The block is built with 2100 as its last year.
  localparam int unsigned EndYear     = 2100;
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned PhaseItems  = 190;
  localparam int unsigned Phases      = 5;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned ScriptRows  = 20;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                advance_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [YearOutW-1:0] cur_year_o;
  logic [MonthW-1:0]   cur_month_o;
  logic [DayW-1:0]     cur_day_o;
  logic [WdayW-1:0]    cur_weekday_o;
  logic                is_target_day_o;
  logic                none_this_year_o;

  // Calendar state and targets as the block should hold them.
  bit [11:0] cal_year;
  bit [3:0]  cal_month;
  bit [4:0]  cal_day;
  bit [2:0]  cal_wday;
  bit [2:0]  occ_count;
  bit        found_year;
  bit [3:0]  want_month;
  bit [2:0]  want_count;
  bit [2:0]  want_wday;

  cnwf_result_t report_q[$];
  int unsigned  mismatches = 0;
  bit           quiet = 1'b0;
  bit           burst = 1'b0;
  bit           hold_req = 1'b0;

  typedef struct {
    bit           adv;
    bit           fixed;
    cnwf_result_t res;
  } script_row_t;

  // Opening days of January 1850; rows with fixed set carry the report typed in.
  script_row_t script [ScriptRows] = '{
    '{1'b0, 1'b1, '{12'd1850, MonthJan, DayFirst, WdayTuesday, 1'b0, 1'b0}},
    '{1'b0, 1'b1, '{12'd1850, MonthJan, DayFirst, WdayTuesday, 1'b0, 1'b0}},
    '{1'b1, 1'b1, '{12'd1850, MonthJan, DayFirst, WdayTuesday, 1'b0, 1'b0}},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b1, '{12'd1850, MonthJan, 5'd7, WdayMonday, 1'b1, 1'b0}},
    '{1'b0, 1'b1, '{12'd1850, MonthJan, 5'd7, WdayMonday, 1'b1, 1'b0}},
    '{1'b1, 1'b1, '{12'd1850, MonthJan, 5'd7, WdayMonday, 1'b1, 1'b0}},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b1, '{12'd1850, MonthJan, 5'd14, WdayMonday, 1'b0, 1'b0}},
    '{1'b0, 1'b1, '{12'd1850, MonthJan, 5'd15, WdayTuesday, 1'b0, 1'b0}},
    '{1'b1, 1'b0, '0}
  };

  calendar_nth_weekday_finder_top #(
    .MaxYear(EndYear)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .advance_i       (advance_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cur_year_o      (cur_year_o),
    .cur_month_o     (cur_month_o),
    .cur_day_o       (cur_day_o),
    .cur_weekday_o   (cur_weekday_o),
    .is_target_day_o (is_target_day_o),
    .none_this_year_o(none_this_year_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit is_leap(input bit [11:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit [4:0] days_in_month(input bit [11:0] y, input bit [3:0] m);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      MonthFeb: return is_leap(y) ? 5'd29 : 5'd28;
      default: return 5'd31;
    endcase
  endfunction

  // Reports the current day for one item and, on advance, moves the calendar on.
  function automatic cnwf_result_t next_report(input bit adv);
    cnwf_result_t r;
    bit           hit;
    bit           dec_last;
    bit [2:0]     cnt_nxt;
    bit           found_nxt;
    cnt_nxt   = occ_count;
    found_nxt = found_year;
    hit       = 1'b0;
    dec_last  = (cal_month == MonthDec) && (cal_day == DayLastDec);
    if ((cal_month == want_month) && (cal_wday == want_wday)) begin
      if (cnt_nxt != CountMax) cnt_nxt++;
      if ((cnt_nxt == want_count) && !found_year) begin
        hit       = 1'b1;
        found_nxt = 1'b1;
      end
    end
    r.year      = cal_year;
    r.month     = cal_month;
    r.day       = cal_day;
    r.weekday   = cal_wday;
    r.is_target = hit;
    r.none_year = dec_last && !found_nxt;
    // The last day of the range holds; nothing moves there.
    if (adv && !(dec_last && cal_year >= EndYear)) begin
      occ_count  = cnt_nxt;
      found_year = found_nxt;
      cal_wday   = (cal_wday == WdaySunday) ? WdayMonday : cal_wday + 3'd1;
      if (cal_day == days_in_month(cal_year, cal_month)) begin
        cal_day = DayFirst;
        if (cal_month == MonthDec) begin
          cal_month  = MonthJan;
          cal_year++;
          occ_count  = '0;
          found_year = 1'b0;
        end else begin
          cal_month++;
        end
      end else begin
        cal_day++;
      end
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap(input bit none);
    int unsigned r;
    if (none) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input bit adv, input bit fixed, input cnwf_result_t fixed_res);
    cnwf_result_t predicted;
    int unsigned  gap;
    gap = idle_gap(quiet || burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    advance_i  <= adv;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_report(adv);
    report_q.push_back(fixed ? fixed_res : predicted);
  endtask

  // Register writes wait until every pending report has come out.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgIdxMonth:   want_month = data;
      CfgIdxCount:   want_count = data[2:0];
      CfgIdxWeekday: want_wday  = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_target(input bit [3:0] m, input bit [3:0] c, input bit [3:0] w);
    write_reg(CfgIdxMonth, m);
    write_reg(CfgIdxCount, c);
    write_reg(CfgIdxWeekday, w);
  endtask

  // Mostly legal targets, sometimes any 4-bit value.
  task automatic random_target();
    bit [3:0] m;
    bit [3:0] c;
    bit [3:0] w;
    m = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
    c = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 5));
    w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 7));
    set_target(m, c, w);
  endtask

  task automatic check_report();
    cnwf_result_t want;
    cnwf_result_t got;
    got = '{cur_year_o, cur_month_o, cur_day_o, cur_weekday_o, is_target_day_o,
            none_this_year_o};
    if (report_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("unexpected report %0d-%0d-%0d wd=%0d target=%0b none=%0b",
                 got.year, got.month, got.day, got.weekday, got.is_target, got.none_year);
      return;
    end
    want = report_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("mismatch: want %0d-%0d-%0d wd=%0d target=%0b none=%0b,",
                 want.year, want.month, want.day, want.weekday, want.is_target,
                 want.none_year,
                 " got %0d-%0d-%0d wd=%0d target=%0b none=%0b",
                 got.year, got.month, got.day, got.weekday,
                 got.is_target, got.none_year);
    end
  endtask

  // Result side: checks each accepted report and stalls at random, or for a long
  // hold when asked.
  initial begin : result_side
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left   = 0;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_report();
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        stall_left = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (stall_left == 0)
          stall_left = ($urandom_range(0, 3) == 0) ? idle_gap(1'b0) : 0;
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned p;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    advance_i   <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgIdxMonth;
    cfg_data_i  <= '0;
    cal_year    = 12'd1850;
    cal_month   = MonthJan;
    cal_day     = DayFirst;
    cal_wday    = WdayTuesday;
    occ_count   = '0;
    found_year  = 1'b0;
    want_month  = 4'd1;
    want_count  = 3'd1;
    want_wday   = 3'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening days with reset targets: report-only repeats and the first Monday.
    for (i = 0; i < ScriptRows; i++)
      send_item(script[i].adv, script[i].fixed, script[i].res);

    // The spare index must change nothing.
    write_reg(CfgIdxSpare, 4'hF);

    // Random phases, each with its own target; halfway the month follows the calendar
    // so that the count carries over and can saturate.
    for (p = 0; p < Phases; p++) begin
      case (p)
        0: set_target(4'd1, 4'd1, 4'd1);
        1: set_target(4'd12, 4'd5, 4'd7);
        2: set_target(4'd0, 4'd0, 4'd0);
        3: set_target(4'd15, 4'd15, 4'd8);
        default: set_target(cal_month, 4'($urandom_range(1, 7)), 4'($urandom_range(1, 7)));
      endcase
      for (i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) write_reg(CfgIdxMonth, cal_month);
        if (i == 40) begin
          hold_req = 1'b1;
          burst    = 1'b1;
        end
        if (i == 64) burst = 1'b0;
        if (i == 100) quiet = 1'b1;
        if (i == 130) quiet = 1'b0;
        send_item($urandom_range(0, 4) != 0, 1'b0, '0);
      end
    end

    // A few closing items around one more target change.
    for (i = 0; i < 12; i++) begin
      if (i == 6) random_target();
      send_item(1'($urandom_range(0, 1)), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== calendar_nth_weekday_finder_top.f =====
hw/rtl/cnwf_pkg.sv
hw/rtl/cnwf_cfg.sv
hw/rtl/cnwf_core.sv
hw/rtl/cnwf_out_buf.sv
hw/rtl/calendar_nth_weekday_finder_top.sv
tb/calendar_nth_weekday_finder_top_tb.sv
